FILE: rtl/psm_pkg.sv
// Shared types and constants for the partition star merge pipeline.
// No dependencies; imported by every module in rtl/.
package psm_pkg;

  localparam int NUM_VERTICES = 9;
  localparam int LABEL_BITS   = 4;
  localparam int CODE_W       = NUM_VERTICES * LABEL_BITS;
  localparam int MASK_W       = NUM_VERTICES;
  localparam int NUM_LABELS   = 1 << LABEL_BITS;
  localparam int VIDX_W       = $clog2(NUM_VERTICES);

  typedef logic [LABEL_BITS-1:0]   label_t;
  typedef logic [VIDX_W-1:0]       vidx_t;
  typedef logic [CODE_W-1:0]       code_t;
  typedef logic [NUM_VERTICES-1:0] vmask_t;

  // After selection check: labels already folded onto the representative.
  typedef struct packed {
    logic                          accepted;
    logic                          pass;
    code_t                         code;
    label_t [NUM_VERTICES-1:0]     labels;
  } psm_s1_t;

  // After first-occurrence search.
  typedef struct packed {
    logic                          accepted;
    logic                          pass;
    code_t                         code;
    vmask_t                        first;
    vidx_t  [NUM_VERTICES-1:0]     src;
  } psm_s2_t;

  typedef struct packed {
    logic                          accepted;
    code_t                         merged_code;
  } psm_out_t;

endpackage

FILE: rtl/psm_check.sv
// Stage 1: duplicate-block check, selection count and merge of selected blocks.
// Depends on psm_pkg.
module psm_check
  import psm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  code_t   in_code,
  input  vmask_t  in_sel,
  output logic    out_valid,
  input  logic    out_ready,
  output psm_s1_t out_data
);

  logic                      valid;
  psm_s1_t                   data;
  psm_s1_t                   data_next;
  label_t [NUM_VERTICES-1:0] lab;
  logic   [NUM_LABELS-1:0]   seen;
  vmask_t                    lowbit;
  label_t                    rep;
  logic                      dup;

  always_comb begin
    seen   = '0;
    dup    = 1'b0;
    rep    = '0;
    lowbit = in_sel & (~in_sel + vmask_t'(1));
    for (int v = 0; v < NUM_VERTICES; v++) begin
      lab[v] = in_code[v*LABEL_BITS +: LABEL_BITS];
    end
    for (int v = 0; v < NUM_VERTICES; v++) begin
      if (in_sel[v]) seen[lab[v]] = 1'b1;
      if (lowbit[v]) rep = rep | lab[v];
      for (int u = 0; u < v; u++) begin
        if (in_sel[u] && in_sel[v] && lab[u] == lab[v]) dup = 1'b1;
      end
    end
    data_next.accepted = !dup;
    // fewer than two selected: code goes through untouched
    data_next.pass     = (in_sel & (in_sel - vmask_t'(1))) == '0;
    data_next.code     = in_code;
    for (int v = 0; v < NUM_VERTICES; v++) begin
      data_next.labels[v] = seen[lab[v]] ? rep : lab[v];
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

endmodule

FILE: rtl/psm_first.sv
// Stage 2: for each vertex, find the lowest vertex with the same merged label.
// Depends on psm_pkg.
module psm_first
  import psm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  psm_s1_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output psm_s2_t out_data
);

  logic    valid;
  psm_s2_t data;
  psm_s2_t data_next;
  vmask_t  eq;
  vmask_t  low;

  always_comb begin
    data_next.accepted = in_data.accepted;
    data_next.pass     = in_data.pass;
    data_next.code     = in_data.code;
    eq  = '0;
    low = '0;
    for (int v = 0; v < NUM_VERTICES; v++) begin
      for (int u = 0; u < NUM_VERTICES; u++) begin
        eq[u] = (u <= v) && (in_data.labels[u] == in_data.labels[v]);
      end
      low = eq & (~eq + vmask_t'(1));
      data_next.src[v] = '0;
      for (int u = 0; u < NUM_VERTICES; u++) begin
        if (low[u]) data_next.src[v] = data_next.src[v] | vidx_t'(u);
      end
      data_next.first[v] = low[v];
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

endmodule

FILE: rtl/psm_renum.sv
// Stage 3: first-occurrence renumbering and output register.
// Depends on psm_pkg.
module psm_renum
  import psm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  psm_s2_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output psm_out_t out_data
);

  logic                      valid;
  psm_out_t                  data;
  psm_out_t                  data_next;
  label_t [NUM_VERTICES-1:0] prefix;
  code_t                     packed_code;

  // new label of a first occurrence = number of first occurrences before it
  always_comb begin
    for (int v = 0; v < NUM_VERTICES; v++) begin
      prefix[v] = '0;
      for (int u = 0; u < v; u++) begin
        prefix[v] = prefix[v] + label_t'(in_data.first[u]);
      end
    end
    for (int v = 0; v < NUM_VERTICES; v++) begin
      packed_code[v*LABEL_BITS +: LABEL_BITS] = prefix[in_data.src[v]];
    end
    data_next.accepted = in_data.accepted;
    if (!in_data.accepted) begin
      data_next.merged_code = '0;
    end else if (in_data.pass) begin
      data_next.merged_code = in_data.code;
    end else begin
      data_next.merged_code = packed_code;
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

endmodule

FILE: rtl/partition_star_merge.sv
// Partition star merge: stream in a packed partition and vertex selection,
// stream out the merged canonical partition with an accept flag.
//
// Input channel s_*: one transfer per item; s_tdata carries partition_code
// in bits 35:0 and selection_mask in bits 44:36. Output channel m_*: one
// transfer per item; m_tdata carries merged_code in bits 35:0, m_tuser is
// the accepted flag (0 means two selected vertices shared a block, and the
// code is then zero).
//
// Three register stages: selection check and block merge, first-occurrence
// search, renumbering into the output register. An item reaches m_tvalid
// after passing through all three registers in that order; one item per
// cycle is sustained while m_tready stays high, as each stage's handshake
// takes a new item as it hands one on, with no recirculation anywhere.
//
// Reset (rst, synchronous) empties all stages; the block holds no other
// state. When the receiver stalls, each stage keeps its item and fills any
// empty stage ahead of it, so up to three items are held before s_tready
// drops; nothing is dropped or repeated.
module partition_star_merge
  import psm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [35:0] partition_code, [44:36] selection_mask
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [35:0] merged_code
  output logic        m_tuser    // [0] accepted
);

  logic     v1;
  logic     r1;
  psm_s1_t  d1;
  logic     v2;
  logic     r2;
  psm_s2_t  d2;
  psm_out_t dout;

  psm_check u_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_code   (s_tdata[CODE_W-1:0]),
    .in_sel    (s_tdata[CODE_W +: MASK_W]),
    .out_valid (v1),
    .out_ready (r1),
    .out_data  (d1)
  );

  psm_first u_first (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_ready  (r1),
    .in_data   (d1),
    .out_valid (v2),
    .out_ready (r2),
    .out_data  (d2)
  );

  psm_renum u_renum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_ready  (r2),
    .in_data   (d2),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (dout)
  );

  assign m_tdata = {{(40-CODE_W){1'b0}}, dout.merged_code};
  assign m_tuser = dout.accepted;

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("rejected item with nonzero code");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && !v1 && !v2)
    else $error("pipeline not empty after reset");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> v1 && v2 && m_tvalid && !m_tready)
    else $error("input stalled while pipeline has room");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for partition_star_merge: drives partition/selection pairs and
// checks each merged partition against a scoreboard. Depends on rtl/psm_pkg.sv and the RTL.
module testbench
  import psm_pkg::*;
();

  localparam int S_PAD = 48 - CODE_W - MASK_W;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 600;

  class merge_scoreboard;
    psm_out_t merged_due[$];
    int errors = 0;
    int noted = 0;
    int checked = 0;
    int rejected = 0;
    int merged = 0;

    task report(string what);
      $display("MISMATCH: %s", what);
      errors++;
    endtask

    // fold the blocks of all selected vertices onto the lowest one, then renumber
    function psm_out_t merge_blocks(code_t code, vmask_t sel);
      psm_out_t res;
      logic [NUM_LABELS-1:0] hit;
      label_t lab;
      label_t head;
      int picks;
      int next_lab;
      int renum [NUM_LABELS];
      hit = '0;
      head = '0;
      picks = 0;
      res.accepted = 1'b1;
      res.merged_code = code;
      for (int v = 0; v < NUM_VERTICES; v++) begin
        lab = code[v*LABEL_BITS +: LABEL_BITS];
        if (sel[v]) begin
          if (hit[lab]) begin
            res.accepted = 1'b0;
            res.merged_code = '0;
            return res;
          end
          hit[lab] = 1'b1;
          if (picks == 0) head = lab;
          picks++;
        end
      end
      if (picks < 2) return res;
      for (int i = 0; i < NUM_LABELS; i++) renum[i] = -1;
      next_lab = 0;
      for (int v = 0; v < NUM_VERTICES; v++) begin
        lab = code[v*LABEL_BITS +: LABEL_BITS];
        if (hit[lab]) lab = head;
        if (renum[lab] < 0) begin
          renum[lab] = next_lab;
          next_lab++;
        end
        res.merged_code[v*LABEL_BITS +: LABEL_BITS] = label_t'(renum[lab]);
      end
      return res;
    endfunction

    function void note_partition(code_t code, vmask_t sel);
      psm_out_t exp_out;
      exp_out = merge_blocks(code, sel);
      merged_due.insert(merged_due.size(), exp_out);
      noted++;
      if (!exp_out.accepted) rejected++;
      else if (exp_out.merged_code != code) merged++;
    endfunction

    task check_merge(logic accepted, code_t merged_code);
      psm_out_t exp_out;
      checked++;
      if (merged_due.size() == 0) begin
        report($sformatf("result %0d with nothing expected: accepted=%b code=%h",
                         checked, accepted, merged_code));
        return;
      end
      exp_out = merged_due.pop_front();
      if (accepted !== exp_out.accepted)
        report($sformatf("result %0d accepted: got %b, want %b",
                         checked, accepted, exp_out.accepted));
      if (merged_code !== exp_out.merged_code)
        report($sformatf("result %0d merged_code: got %h, want %h",
                         checked, merged_code, exp_out.merged_code));
    endtask

    function int pending();
      return merged_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // [35:0] partition_code, [44:36] selection_mask
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // [35:0] merged_code
  logic        m_tuser;        // [0] accepted

  merge_scoreboard sb = new();
  int send_idle = 0;    // percent of cycles the sender idles
  int recv_stall = 0;   // percent of cycles the receiver stalls
  int hold_cycles = 0;  // long hold-off request for the receiver
  int cycles = 0;

  partition_star_merge uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: check on each transfer, then decide whether to take the next one
  int hold_left = 0;
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_merge(m_tuser, m_tdata[CODE_W-1:0]);
    if (hold_cycles > 0) begin
      hold_left = hold_cycles;
      hold_cycles = 0;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  task automatic send_item(input code_t code, input vmask_t sel);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{S_PAD{1'b0}}, sel, code};
    do @(posedge clk); while (!s_tready);
    sb.note_partition(code, sel);
  endtask

  task automatic canonical_code(output code_t code);
    int next_lab;
    int lab;
    code = '0;
    next_lab = 0;
    for (int v = 0; v < NUM_VERTICES; v++) begin
      lab = $urandom_range(0, next_lab);
      if (lab == next_lab) next_lab++;
      code[v*LABEL_BITS +: LABEL_BITS] = label_t'(lab);
    end
  endtask

  // pick at most one vertex per block so the selection is accepted
  task automatic distinct_selection(input code_t code, output vmask_t sel);
    logic [NUM_LABELS-1:0] used;
    label_t lab;
    used = '0;
    sel = '0;
    for (int v = 0; v < NUM_VERTICES; v++) begin
      lab = code[v*LABEL_BITS +: LABEL_BITS];
      if (!used[lab] && $urandom_range(0, 2) != 0) begin
        used[lab] = 1'b1;
        sel[v] = 1'b1;
      end
    end
  endtask

  task automatic random_item();
    code_t code;
    vmask_t sel;
    logic [63:0] raw;
    int kind;
    kind = $urandom_range(0, 99);
    raw = {$urandom, $urandom};
    if (kind < 60) begin
      canonical_code(code);
      distinct_selection(code, sel);
    end else if (kind < 75) begin
      canonical_code(code);
      sel = vmask_t'($urandom);
    end else if (kind < 90) begin
      code = raw[CODE_W-1:0];
      distinct_selection(code, sel);
    end else begin
      code = raw[CODE_W-1:0];
      sel = ($urandom_range(0, 1) == 0) ? '0 : vmask_t'(1 << $urandom_range(0, MASK_W-1));
    end
    send_item(code, sel);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty and single selections, full merges, rejections, odd labels
    send_item(36'h000000000, 9'h000);
    send_item(36'hFFFFFFFFF, 9'h000);
    send_item(36'hFFFFFFFFF, 9'h100);
    send_item(36'h123456789, 9'h010);
    send_item(36'h876543210, 9'h1FF);
    send_item(36'h876543210, 9'h101);
    send_item(36'h876543210, 9'h0AA);
    send_item(36'h876543210, 9'h180);
    send_item(36'h000000000, 9'h003);
    send_item(36'hFFFFFFFFF, 9'h1FF);
    send_item(36'h555555555, 9'h1FF);
    send_item(36'h0FEDCBA98, 9'h1FF);
    send_item(36'hF0F0F0F0F, 9'h003);
    send_item(36'h012012012, 9'h007);
    send_item(36'h000000010, 9'h003);
    send_item(36'h111111110, 9'h003);
    send_item(36'hABCDEF012, 9'h005);
    send_item(36'h001122334, 9'h155);
    send_item(36'h010101010, 9'h0C0);
    send_item(36'h765432100, 9'h1FE);
    drain();

    // long output hold-off with back-to-back input so the pipe fills and stalls
    hold_cycles = 60;
    repeat (20) random_item();
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 80; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 80; end
        default: begin send_idle = 25; recv_stall = 25; end
      endcase
      repeat (RANDOM_ITEMS / 4) random_item();
      drain();
    end

    recv_stall = 0;
    repeat (10) @(posedge clk);
    $display("covered %0d transfers in, %0d results checked (%0d merged, %0d rejected)",
             sb.noted, sb.checked, sb.merged, sb.rejected);
    $display("directed edge cases, output hold-off, and four sender/receiver idle mixes");
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: partition_star_merge.f
rtl/psm_pkg.sv
rtl/psm_check.sv
rtl/psm_first.sv
rtl/psm_renum.sv
rtl/partition_star_merge.sv
bench/testbench.sv
